// ===== rtl/vdd_pkg.sv =====
// ----------------------------------------------------------------------------
// vdd_pkg
// Types and the step function shared by the distance and direction pipeline.
// ----------------------------------------------------------------------------
package vdd_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int RAD_W     = 2 * DIFF_W;
    localparam int ROOT_W    = DIFF_W;
    localparam int REM_W     = ROOT_W + 3;
    localparam int UNIT_FRAC = 30;
    localparam int QUOT_W    = UNIT_FRAC + 1;
    localparam int UNIT_W    = 32;
    localparam int MINL_W    = 16;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUOT_W;

    localparam logic [1:0] REG_MIN_LENGTH = 2'd0;
    localparam logic [15:0] MIN_LENGTH_RESET = 16'd1;

    typedef struct packed {
        logic              valid;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        logic [DIFF_W-1:0] mx;
        logic [DIFF_W-1:0] my;
        logic              nx;
        logic              ny;
    } sqrt_word_t;

    typedef struct packed {
        logic              valid;
        logic [ROOT_W-1:0] len;
        logic [ROOT_W-1:0] rx;
        logic [ROOT_W-1:0] ry;
        logic              bx;
        logic              by;
        logic [QUOT_W-1:0] qx;
        logic [QUOT_W-1:0] qy;
        logic              nx;
        logic              ny;
    } div_word_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic              qbit;
    } div_step_t;

    function automatic div_step_t div_step(input logic [ROOT_W-1:0] rem,
                                           input logic bring,
                                           input logic [ROOT_W-1:0] len);
        logic [ROOT_W:0] r_s;
        div_step_t res;
        r_s = {rem, bring};
        if (r_s >= {1'b0, len}) begin
            r_s = r_s - {1'b0, len};
            res.qbit = 1'b1;
        end else begin
            res.qbit = 1'b0;
        end
        res.rem = r_s[ROOT_W-1:0];
        return res;
    endfunction

endpackage

// ===== rtl/vdd_front.sv =====
// ----------------------------------------------------------------------------
// vdd_front
// Difference, magnitude, squares and sum of squares over three stages.
// ----------------------------------------------------------------------------
module vdd_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [vdd_pkg::COORD_W-1:0] pos_x,
    input  logic [vdd_pkg::COORD_W-1:0] pos_y,
    input  logic [vdd_pkg::COORD_W-1:0] ref_x,
    input  logic [vdd_pkg::COORD_W-1:0] ref_y,
    output vdd_pkg::sqrt_word_t         out_word
);
    localparam int DW = vdd_pkg::DIFF_W;

    logic [DW-1:0] dx, dy;
    logic [DW-1:0] mx_a_reg, my_a_reg, mx_b_reg, my_b_reg;
    logic          nx_a_reg, ny_a_reg, nx_b_reg, ny_b_reg;
    logic [2*DW-1:0] sqx_reg, sqy_reg;
    logic          va_reg, vb_reg;
    vdd_pkg::sqrt_word_t out_reg;

    assign dx = {pos_x[31], pos_x} - {ref_x[31], ref_x};
    assign dy = {pos_y[31], pos_y} - {ref_y[31], ref_y};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            out_reg.valid <= 1'b0;
        end else if (en) begin
            va_reg        <= in_valid;
            vb_reg        <= va_reg;
            out_reg.valid <= vb_reg;
        end
        if (en) begin
            nx_a_reg <= dx[DW-1];
            ny_a_reg <= dy[DW-1];
            mx_a_reg <= dx[DW-1] ? (~dx + 1'b1) : dx;
            my_a_reg <= dy[DW-1] ? (~dy + 1'b1) : dy;
            sqx_reg  <= mx_a_reg * mx_a_reg;
            sqy_reg  <= my_a_reg * my_a_reg;
            mx_b_reg <= mx_a_reg;
            my_b_reg <= my_a_reg;
            nx_b_reg <= nx_a_reg;
            ny_b_reg <= ny_a_reg;
            out_reg.rad  <= sqx_reg + sqy_reg;
            out_reg.rem  <= '0;
            out_reg.root <= '0;
            out_reg.mx   <= mx_b_reg;
            out_reg.my   <= my_b_reg;
            out_reg.nx   <= nx_b_reg;
            out_reg.ny   <= ny_b_reg;
        end
    end

    assign out_word = out_reg;
endmodule

// ===== rtl/vdd_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// vdd_sqrt_cell
// One bit of the digit-by-digit square root, registered.
// ----------------------------------------------------------------------------
module vdd_sqrt_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  vdd_pkg::sqrt_word_t in_word,
    output vdd_pkg::sqrt_word_t out_word
);
    localparam int RW = vdd_pkg::REM_W;

    logic [RW-1:0] rem_s, trial;
    logic          take;
    vdd_pkg::sqrt_word_t out_reg;

    assign rem_s = {in_word.rem[RW-3:0], in_word.rad[vdd_pkg::RAD_W-1 -: 2]};
    assign trial = {1'b0, in_word.root, 2'b01};
    assign take  = rem_s >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg.valid <= in_word.valid;
        end
        if (en) begin
            out_reg.rem  <= take ? (rem_s - trial) : rem_s;
            out_reg.root <= {in_word.root[vdd_pkg::ROOT_W-2:0], take};
            out_reg.rad  <= {in_word.rad[vdd_pkg::RAD_W-3:0], 2'b00};
            out_reg.mx   <= in_word.mx;
            out_reg.my   <= in_word.my;
            out_reg.nx   <= in_word.nx;
            out_reg.ny   <= in_word.ny;
        end
    end

    assign out_word = out_reg;
endmodule

// ===== rtl/vdd_div_cell.sv =====
// ----------------------------------------------------------------------------
// vdd_div_cell
// One quotient bit of both restoring divisions, registered.
// ----------------------------------------------------------------------------
module vdd_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  vdd_pkg::div_word_t in_word,
    output vdd_pkg::div_word_t out_word
);
    vdd_pkg::div_step_t sx, sy;
    vdd_pkg::div_word_t out_reg;

    assign sx = vdd_pkg::div_step(in_word.rx, in_word.bx, in_word.len);
    assign sy = vdd_pkg::div_step(in_word.ry, in_word.by, in_word.len);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg.valid <= in_word.valid;
        end
        if (en) begin
            out_reg.len <= in_word.len;
            out_reg.rx  <= sx.rem;
            out_reg.ry  <= sy.rem;
            out_reg.bx  <= 1'b0;
            out_reg.by  <= 1'b0;
            out_reg.qx  <= {in_word.qx[vdd_pkg::QUOT_W-2:0], sx.qbit};
            out_reg.qy  <= {in_word.qy[vdd_pkg::QUOT_W-2:0], sy.qbit};
            out_reg.nx  <= in_word.nx;
            out_reg.ny  <= in_word.ny;
        end
    end

    assign out_word = out_reg;
endmodule

// ===== rtl/vector_distance_and_direction.sv =====
// ----------------------------------------------------------------------------
// vector_distance_and_direction
// Euclidean length and unit direction of p - q.
// ----------------------------------------------------------------------------
// One word per cycle is accepted while the output is not stalled; one result
// word leaves per input word. The path: three front stages (difference, squares,
// sum), 33 square-root cells, 31 divider cells and the output register.
// The whole row advances together and holds while the output word is not taken.
module vector_distance_and_direction (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x [31:0], pos_y [63:32], ref_x [95:64], ref_y [127:96]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // length [32:0], unit_x [64:33], unit_y [96:65], zero [103:97]
    output logic [103:0] m_tdata,
    // degenerate [0]
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int NS = vdd_pkg::SQRT_STEPS;
    localparam int ND = vdd_pkg::DIV_STEPS;
    localparam int LW = vdd_pkg::ROOT_W;

    logic en;
    logic [vdd_pkg::MINL_W-1:0] min_length_reg;
    vdd_pkg::sqrt_word_t sq_w [0:NS];
    vdd_pkg::div_word_t  dv_w [0:ND];
    vdd_pkg::div_word_t  fin;

    logic          m_valid_reg;
    logic [LW-1:0] len_reg;
    logic [31:0]   ux_reg, uy_reg;
    logic          degen_reg;
    logic          degen;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign pready   = 1'b1;
    assign prdata   = {16'd0, min_length_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg <= vdd_pkg::MIN_LENGTH_RESET;
        end else if (psel && penable && pwrite && paddr == vdd_pkg::REG_MIN_LENGTH) begin
            min_length_reg <= pwdata[vdd_pkg::MINL_W-1:0];
        end
    end

    vdd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .pos_x    (s_tdata[31:0]),
        .pos_y    (s_tdata[63:32]),
        .ref_x    (s_tdata[95:64]),
        .ref_y    (s_tdata[127:96]),
        .out_word (sq_w[0])
    );

    for (genvar i = 0; i < NS; i++) begin : g_sqrt
        vdd_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_word  (sq_w[i]),
            .out_word (sq_w[i+1])
        );
    end

    always_comb begin
        dv_w[0].valid = sq_w[NS].valid;
        dv_w[0].len   = sq_w[NS].root;
        dv_w[0].rx    = {1'b0, sq_w[NS].mx[LW-1:1]};
        dv_w[0].ry    = {1'b0, sq_w[NS].my[LW-1:1]};
        dv_w[0].bx    = sq_w[NS].mx[0];
        dv_w[0].by    = sq_w[NS].my[0];
        dv_w[0].qx    = '0;
        dv_w[0].qy    = '0;
        dv_w[0].nx    = sq_w[NS].nx;
        dv_w[0].ny    = sq_w[NS].ny;
    end

    for (genvar j = 0; j < ND; j++) begin : g_div
        vdd_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_word  (dv_w[j]),
            .out_word (dv_w[j+1])
        );
    end

    assign fin   = dv_w[ND];
    assign degen = (fin.len <= {17'd0, min_length_reg}) || (fin.len == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= fin.valid;
        end
        if (en) begin
            len_reg   <= fin.len;
            degen_reg <= degen;
            ux_reg    <= degen ? 32'd0 : (fin.nx ? (32'd0 - {1'b0, fin.qx}) : {1'b0, fin.qx});
            uy_reg    <= degen ? 32'd0 : (fin.ny ? (32'd0 - {1'b0, fin.qy}) : {1'b0, fin.qy});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, uy_reg, ux_reg, len_reg};
    assign m_tuser  = degen_reg;
endmodule

// ===== rtl/vdd_checker.sv =====
// ----------------------------------------------------------------------------
// vdd_checker
// Port-level checks of the distance and direction block.
// ----------------------------------------------------------------------------
module vdd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic [0:0]   m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[96:33] == 64'd0)
        else $error("degenerate result with nonzero direction");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[32:0] > 33'd0)
        else $error("direction given for a zero length");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind vector_distance_and_direction vdd_checker u_vdd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
